// ----- rtl/core/mcu_host_mailbox_dma_bridge_assert.svh -----
// Assertion macros for the host/MCU mailbox bridge checkers.
// Needs a clk and an active-low rst_n in the scope of each use.
`ifndef MCU_HOST_MAILBOX_DMA_BRIDGE_ASSERT_SVH
`define MCU_HOST_MAILBOX_DMA_BRIDGE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HMDB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define HMDB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/hmdb_pkg.sv -----
// Shared types and constants for the host/MCU mailbox bridge.
// No dependencies; imported by hmdb_core and the top module.
package hmdb_pkg;

  typedef enum logic [2:0] {
    REQ_HOST_PORT_RD = 3'd0,
    REQ_HOST_PORT_WR = 3'd1,
    REQ_MCU_RD       = 3'd2,
    REQ_MCU_WR       = 3'd3,
    REQ_HOST_MEM_WR  = 3'd4,
    REQ_HOST_MEM_RD  = 3'd5
  } hmdb_req_t;

  // MCU register map (low 11 address bits)
  localparam logic [10:0] MCU_ADDR_PORT_A = 11'd0;
  localparam logic [10:0] MCU_ADDR_PORT_B = 11'd1;
  localparam logic [10:0] MCU_ADDR_STATUS = 11'd2;

  // Port B strobe bit positions (enable active high, the rest active low)
  localparam int unsigned PB_ENABLE   = 0;
  localparam int unsigned PB_TAKE     = 1;
  localparam int unsigned PB_SEND     = 2;
  localparam int unsigned PB_BUSREQ   = 3;
  localparam int unsigned PB_MEM_WR   = 4;
  localparam int unsigned PB_MEM_RD   = 5;
  localparam int unsigned PB_ADDR_LO  = 6;
  localparam int unsigned PB_ADDR_HI  = 7;

  localparam logic [7:0] PORT_B_READ = 8'hff;

  // One result word as it leaves the decode stage
  typedef struct packed {
    logic [7:0] read_data;
    logic       use_mem;
    logic       handled;
    logic       mcu_irq;
    logic       bus_request;
  } hmdb_res_t;

endpackage

// ----- rtl/core/hmdb_if.sv -----
// Valid/ready channel interfaces for the host/MCU mailbox bridge.
// Standalone; no package needed.
interface hmdb_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [15:0] address;
  logic [7:0]  write_data;
  modport source (output valid, req_type, address, write_data, input ready);
  modport sink   (input valid, req_type, address, write_data, output ready);
endinterface

interface hmdb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       handled;
  logic       mcu_irq;
  logic       bus_request;
  modport source (output valid, read_data, handled, mcu_irq, bus_request, input ready);
  modport sink   (input valid, read_data, handled, mcu_irq, bus_request, output ready);
endinterface

interface hmdb_cfg_if;
  logic valid;
  logic ready;
  logic mcu_present;
  modport source (output valid, mcu_present, input ready);
  modport sink   (input valid, mcu_present, output ready);
endinterface

// ----- rtl/core/hmdb_ram.sv -----
// Shared byte memory: one write port, one read port, registered read data.
// No package dependency.
module hmdb_ram #(
  parameter int MEM_ADDR_BITS = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [MEM_ADDR_BITS-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic                     re,
  input  logic [MEM_ADDR_BITS-1:0] raddr,
  output logic [7:0]               rdata
);

  logic [7:0] mem [2**MEM_ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/hmdb_core.sv -----
// Decode stage and mailbox/latch state of the host/MCU bridge.
// Uses hmdb_pkg; drives the shared memory ports of hmdb_ram.
module hmdb_core #(
  parameter int MEM_ADDR_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_acc,
  input  logic [2:0]               req_type,
  input  logic [15:0]              address,
  input  logic [7:0]               write_data,
  input  logic                     cfg_we,
  input  logic                     cfg_data,
  input  logic [7:0]               mem_rdata,
  output logic                     mem_we,
  output logic [MEM_ADDR_BITS-1:0] mem_waddr,
  output logic [7:0]               mem_wdata,
  output logic                     mem_re,
  output logic [MEM_ADDR_BITS-1:0] mem_raddr,
  output hmdb_pkg::hmdb_res_t      res
);
  import hmdb_pkg::*;

  logic        present_r;
  logic        host_ready_r, host_ready_nxt;
  logic        host_accept_r, host_accept_nxt;
  logic        bus_req_r, bus_req_nxt;
  logic        irq_r, irq_nxt;
  logic [7:0]  to_host_r, to_host_nxt;
  logic [7:0]  from_host_r, from_host_nxt;
  logic [7:0]  pa_in_r, pa_in_nxt;
  logic [7:0]  pa_out_r, pa_out_nxt;
  logic [15:0] dma_r, dma_nxt;
  logic        pend_r, pend_nxt;

  logic [7:0]  pa_in_eff;
  logic [10:0] maddr;
  logic [15:0] dma_inc;
  logic [7:0]  pb;

  // a DMA read issued last cycle lands in port A in now
  assign pa_in_eff = pend_r ? mem_rdata : pa_in_r;
  assign maddr     = address[10:0];
  assign pb        = write_data;
  assign dma_inc   = {dma_r[15:8], dma_r[7:0] + 8'd1};

  always_comb begin
    host_ready_nxt  = host_ready_r;
    host_accept_nxt = host_accept_r;
    bus_req_nxt     = bus_req_r;
    irq_nxt         = irq_r;
    to_host_nxt     = to_host_r;
    from_host_nxt   = from_host_r;
    pa_in_nxt       = pa_in_eff;
    pa_out_nxt      = pa_out_r;
    dma_nxt         = dma_r;
    pend_nxt        = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = address[MEM_ADDR_BITS-1:0];
    mem_wdata       = write_data;
    mem_re          = 1'b0;
    mem_raddr       = address[MEM_ADDR_BITS-1:0];
    res.read_data   = 8'h00;
    res.use_mem     = 1'b0;
    res.handled     = 1'b1;

    if (in_acc) begin
      unique case (req_type)
        REQ_HOST_PORT_RD: begin
          if (present_r) begin
            if (!address[0]) begin
              host_accept_nxt = 1'b1;
              res.read_data   = to_host_r;
            end else begin
              res.read_data = ~{6'd0, host_accept_r, host_ready_r};
            end
          end
        end
        REQ_HOST_PORT_WR: begin
          if (present_r && !address[0]) begin
            host_ready_nxt = 1'b1;
            irq_nxt        = 1'b1;
            from_host_nxt  = write_data;
          end
        end
        REQ_MCU_RD: begin
          priority if (maddr == MCU_ADDR_PORT_A) begin
            res.read_data = pa_in_eff;
          end else if (maddr == MCU_ADDR_PORT_B) begin
            res.read_data = PORT_B_READ;
          end else if (maddr == MCU_ADDR_STATUS) begin
            res.read_data = {5'd0, !bus_req_r, host_accept_r, host_ready_r};
          end else begin
            res.handled = 1'b0;
          end
        end
        REQ_MCU_WR: begin
          priority if (maddr == MCU_ADDR_PORT_A) begin
            pa_out_nxt = write_data;
          end else if (maddr == MCU_ADDR_PORT_B) begin
            if (pb[PB_ENABLE]) begin
              if (!pb[PB_TAKE]) begin
                host_ready_nxt = 1'b0;
                irq_nxt        = 1'b0;
                pa_in_nxt      = from_host_r;
              end
              bus_req_nxt = !pb[PB_BUSREQ];
              if (!pb[PB_SEND]) begin
                to_host_nxt     = pa_out_r;
                host_accept_nxt = 1'b0;
              end
              // write at the old address; read at the bumped one when also writing, else the old
              mem_waddr = dma_r[MEM_ADDR_BITS-1:0];
              mem_wdata = pa_out_r;
              mem_raddr = dma_r[MEM_ADDR_BITS-1:0];
              if (!pb[PB_MEM_WR]) begin
                mem_we    = 1'b1;
                dma_nxt   = dma_inc;
                mem_raddr = dma_inc[MEM_ADDR_BITS-1:0];
              end
              if (!pb[PB_MEM_RD]) begin
                mem_re   = 1'b1;
                pend_nxt = 1'b1;
              end
              if (!pb[PB_ADDR_LO]) begin
                dma_nxt[7:0] = pa_out_r;
              end
              if (!pb[PB_ADDR_HI]) begin
                dma_nxt[15:8] = pa_out_r;
              end
            end
          end else begin
            res.handled = 1'b0;
          end
        end
        REQ_HOST_MEM_WR: begin
          mem_we = 1'b1;
        end
        REQ_HOST_MEM_RD: begin
          mem_re      = 1'b1;
          res.use_mem = 1'b1;
        end
        default: begin
          res.handled = 1'b0;
        end
      endcase
    end

    res.mcu_irq     = irq_nxt;
    res.bus_request = bus_req_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r     <= 1'b1;
      host_ready_r  <= 1'b0;
      host_accept_r <= 1'b1;
      bus_req_r     <= 1'b0;
      irq_r         <= 1'b0;
      to_host_r     <= 8'h00;
      from_host_r   <= 8'h00;
      pa_in_r       <= 8'h00;
      pa_out_r      <= 8'h00;
      dma_r         <= 16'h0000;
      pend_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        present_r <= cfg_data;
      end
      host_ready_r  <= host_ready_nxt;
      host_accept_r <= host_accept_nxt;
      bus_req_r     <= bus_req_nxt;
      irq_r         <= irq_nxt;
      to_host_r     <= to_host_nxt;
      from_host_r   <= from_host_nxt;
      pa_in_r       <= pa_in_nxt;
      pa_out_r      <= pa_out_nxt;
      dma_r         <= dma_nxt;
      pend_r        <= pend_nxt;
    end
  end

endmodule

// ----- rtl/core/mcu_host_mailbox_dma_bridge.sv -----
// Host/MCU mailbox and DMA bridge. One result word comes back for every
// request word, in order. A request is decoded in the cycle it is accepted:
// mailbox flags, port A latches and the DMA address update at once, and the
// shared memory is written or read there. The memory has registered read
// data, so the result waits in a second stage where a memory read
// completes, and then in an output register. A new word can be taken
// every cycle while the output is not stalled. A port B word that both
// writes and reads memory does so in the same cycle on the two memory
// ports. A DMA read lands in port A in the cycle after and is
// forwarded to a request that reads port A in that cycle. Shared memory
// entries hold garbage until written. Configuration is always ready.
// Depends on hmdb_pkg, hmdb_if, hmdb_ram and hmdb_core.
module mcu_host_mailbox_dma_bridge #(
  parameter int MEM_ADDR_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  hmdb_in_if.sink    in_bus,
  hmdb_out_if.source out_bus,
  hmdb_cfg_if.sink   cfg_bus
);
  import hmdb_pkg::*;

  logic                     in_acc;
  logic                     mem_we;
  logic [MEM_ADDR_BITS-1:0] mem_waddr;
  logic [7:0]               mem_wdata;
  logic                     mem_re;
  logic [MEM_ADDR_BITS-1:0] mem_raddr;
  logic [7:0]               mem_rdata;
  hmdb_res_t                res;

  // second stage: waits for memory read data
  logic                     s2_valid_r, s2_valid_nxt;
  hmdb_res_t                s2_r;
  logic                     s2_adv;
  // output register
  logic                     o_valid_r, o_valid_nxt;
  logic [7:0]               o_data_r;
  logic                     o_handled_r;
  logic                     o_irq_r;
  logic                     o_busreq_r;

  // advance stage 2 when the output register is free or draining
  assign s2_adv       = !o_valid_r || out_bus.ready;
  assign in_bus.ready = !s2_valid_r || s2_adv;
  assign in_acc       = in_bus.valid && in_bus.ready;
  assign cfg_bus.ready = 1'b1;

  hmdb_core #(.MEM_ADDR_BITS(MEM_ADDR_BITS)) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_acc     (in_acc),
    .req_type   (in_bus.req_type),
    .address    (in_bus.address),
    .write_data (in_bus.write_data),
    .cfg_we     (cfg_bus.valid),
    .cfg_data   (cfg_bus.mcu_present),
    .mem_rdata  (mem_rdata),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .res        (res)
  );

  hmdb_ram #(.MEM_ADDR_BITS(MEM_ADDR_BITS)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    s2_valid_nxt = s2_valid_r;
    o_valid_nxt  = o_valid_r;
    if (o_valid_r && out_bus.ready) begin
      o_valid_nxt = 1'b0;
    end
    if (s2_valid_r && s2_adv) begin
      o_valid_nxt  = 1'b1;
      s2_valid_nxt = 1'b0;
    end
    if (in_acc) begin
      s2_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
    end else begin
      s2_valid_r <= s2_valid_nxt;
      o_valid_r  <= o_valid_nxt;
    end
  end

  // payload: no reset needed; memory data held stable while stage 2 waits
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s2_r <= res;
    end
    if (s2_valid_r && s2_adv) begin
      o_data_r    <= s2_r.use_mem ? mem_rdata : s2_r.read_data;
      o_handled_r <= s2_r.handled;
      o_irq_r     <= s2_r.mcu_irq;
      o_busreq_r  <= s2_r.bus_request;
    end
  end

  assign out_bus.valid       = o_valid_r;
  assign out_bus.read_data   = o_data_r;
  assign out_bus.handled     = o_handled_r;
  assign out_bus.mcu_irq     = o_irq_r;
  assign out_bus.bus_request = o_busreq_r;

endmodule

// ----- rtl/core/hmdb_chk.sv -----
// Port-level checker for the host/MCU mailbox bridge, bound to the top.
// Uses the assertion macros header.
`include "mcu_host_mailbox_dma_bridge_assert.svh"

module hmdb_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_read_data,
  input logic       out_handled,
  input logic       cfg_ready
);

  `HMDB_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_read_data) && $stable(out_handled), "stalled result word changed")
  `HMDB_ASSERT_NOW(a_unhandled_zero, out_valid && !out_handled, out_read_data == 8'h00, "undecoded access returned data")
  `HMDB_ASSERT_NOW(a_cfg_ready, 1'b1, cfg_ready, "config port not ready")

endmodule

bind mcu_host_mailbox_dma_bridge hmdb_chk u_hmdb_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_bus.valid),
  .out_ready     (out_bus.ready),
  .out_read_data (out_bus.read_data),
  .out_handled   (out_bus.handled),
  .cfg_ready     (cfg_bus.ready)
);
